/* rtl/alm_pkg.sv */
// Shared types and constants for the array linked list manager.
// Used by alm_node_store and array_linked_list_manager_unit; no dependencies.
package alm_pkg;

    localparam int NODES  = 255;
    localparam int SLOTS  = NODES + 1;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int LINK_W = 9;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 4;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 8;

    localparam logic [CMD_W-1:0] CMD_INS_HEAD   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_INS_SORTED = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DEL_AT     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DEL_VALUE  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SRCH_FWD   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SRCH_BACK  = 4'd9;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_LOC   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] item;
        logic [LINK_W-1:0]        location;
    } alm_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LINK_W-1:0] node_location;
        logic [CNT_W-1:0]  count;
    } alm_out_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              val_we;
        logic [ADDR_W-1:0] val_waddr;
        logic [DATA_W-1:0] val_wdata;
        logic              nx_we;
        logic [ADDR_W-1:0] nx_waddr;
        logic [LINK_W-1:0] nx_wdata;
        logic              pv_we;
        logic [ADDR_W-1:0] pv_waddr;
        logic [LINK_W-1:0] pv_wdata;
    } alm_store_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } alm_store_rsp_t;

endpackage

/* rtl/array_linked_list_manager_unit.sv */
// Circular doubly linked list manager over RAM-based node stores with a free chain.
// One command item in, one result item out. Slot 0 is the header. An item that
// fails its checks or is unused goes straight to the result; head, tail and
// positional inserts and deletes pass through the insert or delete states, and
// sorted insert, value delete and search first walk the list; the walk is bounded
// by the single read port of the link stores, which yields one link per cycle.
// A finished result sits in the output register while the next item is taken; a
// result still waiting there when the next one finishes holds the block.
// Depends on alm_pkg and alm_node_store.
module array_linked_list_manager_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  alm_pkg::alm_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output alm_pkg::alm_out_t m_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HEAD  = 9'b000000010,
        S_WALK  = 9'b000000100,
        S_INS_A = 9'b000001000,
        S_INS_B = 9'b000010000,
        S_INS_C = 9'b000100000,
        S_DEL_A = 9'b001000000,
        S_DEL_B = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    localparam int LW = alm_pkg::LINK_W;
    localparam int AW = alm_pkg::ADDR_W;

    state_t                         state_reg, state_next;
    logic [alm_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic signed [alm_pkg::DATA_W-1:0] item_reg, item_next;
    logic [LW-1:0]                  cur_reg, cur_next;
    logic [LW-1:0]                  pnode_reg, pnode_next;
    logic [LW-1:0]                  nx_reg, nx_next;
    logic [LW-1:0]                  fnext_reg, fnext_next;
    logic [LW-1:0]                  free_head_reg, free_head_next;
    logic [alm_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [alm_pkg::SLOTS-1:0]      live_reg, live_next;
    logic [alm_pkg::STAT_W-1:0]     res_status_reg, res_status_next;
    logic [LW-1:0]                  res_loc_reg, res_loc_next;
    logic                           m_valid_reg, m_valid_next;
    alm_pkg::alm_out_t              m_data_reg, m_data_next;

    alm_pkg::alm_store_req_t req;
    alm_pkg::alm_store_rsp_t rsp;

    logic          loc_ok;
    logic          full;
    logic          accept;
    logic [LW-1:0] head_link;
    logic [LW-1:0] walk_link;
    logic          backward;

    alm_node_store u_store (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (req),
        .rsp    (rsp)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign full     = free_head_reg > LW'(alm_pkg::NODES);
    assign loc_ok   = (s_data.location <= LW'(alm_pkg::NODES)) &&
                      ((s_data.location == '0) || live_reg[s_data.location[AW-1:0]]);
    assign backward = (cmd_reg == alm_pkg::CMD_INS_TAIL) || (cmd_reg == alm_pkg::CMD_DEL_TAIL)
                   || (cmd_reg == alm_pkg::CMD_SRCH_BACK);
    assign head_link = backward ? rsp.prv : rsp.nxt;
    assign walk_link = (cmd_reg == alm_pkg::CMD_SRCH_BACK) ? rsp.prv : rsp.nxt;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        item_next       = item_reg;
        cur_next        = cur_reg;
        pnode_next      = pnode_reg;
        nx_next         = nx_reg;
        fnext_next      = fnext_reg;
        free_head_next  = free_head_reg;
        count_next      = count_reg;
        live_next       = live_reg;
        res_status_next = res_status_reg;
        res_loc_next    = res_loc_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        req             = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next        = s_data.command;
                    item_next       = s_data.item;
                    res_status_next = alm_pkg::ST_OK;
                    res_loc_next    = '0;
                    state_next      = S_DONE;
                    case (s_data.command) inside
                        [alm_pkg::CMD_INS_HEAD:alm_pkg::CMD_INS_SORTED]: begin
                            if (s_data.command == alm_pkg::CMD_INS_AFTER && !loc_ok) begin
                                res_status_next = alm_pkg::ST_BAD_LOC;
                            end else if (full) begin
                                res_status_next = alm_pkg::ST_OVERFLOW;
                            end else if (s_data.command == alm_pkg::CMD_INS_HEAD) begin
                                pnode_next = '0;
                                state_next = S_INS_A;
                            end else if (s_data.command == alm_pkg::CMD_INS_AFTER) begin
                                pnode_next  = s_data.location;
                                req.rd_addr = s_data.location[AW-1:0];
                                state_next  = S_INS_A;
                            end else begin
                                state_next = S_HEAD;
                            end
                        end
                        [alm_pkg::CMD_DEL_HEAD:alm_pkg::CMD_DEL_VALUE]: begin
                            if (count_reg == '0) begin
                                res_status_next = alm_pkg::ST_UNDERFLOW;
                            end else if (s_data.command == alm_pkg::CMD_DEL_AT) begin
                                if (s_data.location == '0 || !loc_ok) begin
                                    res_status_next = alm_pkg::ST_BAD_LOC;
                                end else begin
                                    cur_next    = s_data.location;
                                    req.rd_addr = s_data.location[AW-1:0];
                                    state_next  = S_DEL_A;
                                end
                            end else begin
                                state_next = S_HEAD;
                            end
                        end
                        alm_pkg::CMD_SRCH_FWD, alm_pkg::CMD_SRCH_BACK: begin
                            state_next = S_HEAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HEAD: begin
                case (cmd_reg)
                    alm_pkg::CMD_INS_TAIL: begin
                        pnode_next  = head_link;
                        req.rd_addr = head_link[AW-1:0];
                        state_next  = S_INS_A;
                    end
                    alm_pkg::CMD_DEL_HEAD, alm_pkg::CMD_DEL_TAIL: begin
                        cur_next    = head_link;
                        req.rd_addr = head_link[AW-1:0];
                        state_next  = S_DEL_A;
                    end
                    alm_pkg::CMD_INS_SORTED: begin
                        pnode_next  = '0;
                        req.rd_addr = head_link[AW-1:0];
                        if (head_link == '0) begin
                            state_next = S_INS_A;
                        end else begin
                            cur_next   = head_link;
                            state_next = S_WALK;
                        end
                    end
                    default: begin
                        if (head_link == '0) begin
                            res_status_next = alm_pkg::ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end else begin
                            cur_next    = head_link;
                            req.rd_addr = head_link[AW-1:0];
                            state_next  = S_WALK;
                        end
                    end
                endcase
            end
            S_WALK: begin
                if (cmd_reg == alm_pkg::CMD_INS_SORTED) begin
                    if (item_reg >= $signed(rsp.val)) begin
                        pnode_next = cur_reg;
                        if (walk_link == '0) begin
                            req.rd_addr = cur_reg[AW-1:0];
                            state_next  = S_INS_A;
                        end else begin
                            cur_next    = walk_link;
                            req.rd_addr = walk_link[AW-1:0];
                        end
                    end else begin
                        req.rd_addr = pnode_reg[AW-1:0];
                        state_next  = S_INS_A;
                    end
                end else if (rsp.val == item_reg) begin
                    if (cmd_reg == alm_pkg::CMD_DEL_VALUE) begin
                        req.rd_addr = cur_reg[AW-1:0];
                        state_next  = S_DEL_A;
                    end else begin
                        res_loc_next = cur_reg;
                        state_next   = S_DONE;
                    end
                end else if (walk_link == '0) begin
                    res_status_next = alm_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end else begin
                    cur_next    = walk_link;
                    req.rd_addr = walk_link[AW-1:0];
                end
            end
            S_INS_A: begin
                nx_next     = rsp.nxt;
                req.rd_addr = free_head_reg[AW-1:0];
                state_next  = S_INS_B;
            end
            S_INS_B: begin
                fnext_next    = rsp.nxt;
                req.val_we    = 1'b1;
                req.val_waddr = free_head_reg[AW-1:0];
                req.val_wdata = item_reg;
                req.nx_we     = 1'b1;
                req.nx_waddr  = free_head_reg[AW-1:0];
                req.nx_wdata  = nx_reg;
                req.pv_we     = 1'b1;
                req.pv_waddr  = free_head_reg[AW-1:0];
                req.pv_wdata  = pnode_reg;
                state_next    = S_INS_C;
            end
            S_INS_C: begin
                req.nx_we    = 1'b1;
                req.nx_waddr = pnode_reg[AW-1:0];
                req.nx_wdata = free_head_reg;
                req.pv_we    = 1'b1;
                req.pv_waddr = nx_reg[AW-1:0];
                req.pv_wdata = free_head_reg;
                live_next[free_head_reg[AW-1:0]] = 1'b1;
                count_next     = count_reg + 1'b1;
                free_head_next = fnext_reg;
                res_loc_next   = free_head_reg;
                state_next     = S_DONE;
            end
            S_DEL_A: begin
                req.nx_we    = 1'b1;
                req.nx_waddr = rsp.prv[AW-1:0];
                req.nx_wdata = rsp.nxt;
                req.pv_we    = 1'b1;
                req.pv_waddr = rsp.nxt[AW-1:0];
                req.pv_wdata = rsp.prv;
                state_next   = S_DEL_B;
            end
            S_DEL_B: begin
                req.nx_we    = 1'b1;
                req.nx_waddr = cur_reg[AW-1:0];
                req.nx_wdata = free_head_reg;
                live_next[cur_reg[AW-1:0]] = 1'b0;
                count_next     = count_reg - 1'b1;
                free_head_next = cur_reg;
                res_loc_next   = cur_reg;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = res_status_reg;
                    m_data_next.node_location = res_loc_reg;
                    m_data_next.count         = count_reg;
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= LW'(1);
            count_reg     <= '0;
            live_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            live_reg      <= live_next;
            m_valid_reg   <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        item_reg       <= item_next;
        cur_reg        <= cur_next;
        pnode_reg      <= pnode_next;
        nx_reg         <= nx_next;
        fnext_reg      <= fnext_next;
        res_status_reg <= res_status_next;
        res_loc_reg    <= res_loc_next;
        m_data_reg     <= m_data_next;
    end

    a_free_head_not_header: assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg != '0)
        else $error("free chain points at the header");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= alm_pkg::CNT_W'(alm_pkg::NODES))
        else $error("node count above capacity");

    a_ins_has_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INS_B |-> free_head_reg <= LW'(alm_pkg::NODES))
        else $error("insert started with no free node");

    a_del_not_header: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DEL_B |-> (cur_reg != '0 && live_reg[cur_reg[AW-1:0]]))
        else $error("unlinking the header or a dead node");

    a_count_tracks_live: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(live_reg) == int'(count_reg))
        else $error("live map and node count disagree");

endmodule

/* rtl/alm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/alm_node_store.sv */
// Node stores: values, forward links and backward links in three RAMs.
// Forward links carry written bits so unwritten links read their reset value.
// Depends on alm_pkg and alm_ram.
module alm_node_store (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  alm_pkg::alm_store_req_t req,
    output alm_pkg::alm_store_rsp_t rsp
);

    logic [alm_pkg::SLOTS-1:0]  nx_vld_reg;
    logic                       pv0_vld_reg;
    logic                       nx_hit_reg;
    logic                       pv_hit_reg;
    logic [alm_pkg::ADDR_W-1:0] raddr_reg;
    logic [alm_pkg::LINK_W-1:0] nx_dout;
    logic [alm_pkg::LINK_W-1:0] pv_dout;
    logic [alm_pkg::LINK_W-1:0] nx_rst_val;

    alm_ram #(.WIDTH(alm_pkg::DATA_W), .DEPTH(alm_pkg::SLOTS)) u_val_ram (
        .aclk (aclk),
        .we   (req.val_we),
        .waddr(req.val_waddr),
        .wdata(req.val_wdata),
        .raddr(req.rd_addr),
        .rdata(rsp.val)
    );

    alm_ram #(.WIDTH(alm_pkg::LINK_W), .DEPTH(alm_pkg::SLOTS)) u_next_ram (
        .aclk (aclk),
        .we   (req.nx_we),
        .waddr(req.nx_waddr),
        .wdata(req.nx_wdata),
        .raddr(req.rd_addr),
        .rdata(nx_dout)
    );

    alm_ram #(.WIDTH(alm_pkg::LINK_W), .DEPTH(alm_pkg::SLOTS)) u_prev_ram (
        .aclk (aclk),
        .we   (req.pv_we),
        .waddr(req.pv_waddr),
        .wdata(req.pv_wdata),
        .raddr(req.rd_addr),
        .rdata(pv_dout)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_vld_reg  <= '0;
            pv0_vld_reg <= 1'b0;
        end else begin
            if (req.nx_we) begin
                nx_vld_reg[req.nx_waddr] <= 1'b1;
            end
            if (req.pv_we && req.pv_waddr == '0) begin
                pv0_vld_reg <= 1'b1;
            end
        end
        nx_hit_reg <= nx_vld_reg[req.rd_addr];
        pv_hit_reg <= (req.rd_addr != '0) || pv0_vld_reg;
        raddr_reg  <= req.rd_addr;
    end

    // header links to itself, free slot i links to i+1
    assign nx_rst_val = (raddr_reg == '0) ? '0
                      : alm_pkg::LINK_W'(raddr_reg) + alm_pkg::LINK_W'(1);
    assign rsp.nxt = nx_hit_reg ? nx_dout : nx_rst_val;
    // only the header back link is read before it is written
    assign rsp.prv = pv_hit_reg ? pv_dout : '0;

endmodule

/* tb/tb_array_linked_list_manager_unit.sv */
// Testbench for array_linked_list_manager_unit: drives list commands, predicts results.
// Directed table with fixed expectations where obvious, then random traffic.
// Depends on alm_pkg and the RTL of the block.
module tb_array_linked_list_manager_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    alm_pkg::alm_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    alm_pkg::alm_out_t m_data;

    array_linked_list_manager_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // list image
    logic signed [alm_pkg::DATA_W-1:0] val_mem [alm_pkg::SLOTS];
    logic [alm_pkg::LINK_W-1:0] nxt_mem [alm_pkg::SLOTS];
    logic [alm_pkg::LINK_W-1:0] prv_mem [alm_pkg::SLOTS];
    bit                         in_list [alm_pkg::SLOTS];
    int                         free_slot;
    int                         list_len;

    alm_pkg::alm_out_t pending_results [$];
    int                err_cnt;
    int                idle_cycles;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch %s got %0d want %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic void list_reset();
        for (int i = 0; i < alm_pkg::SLOTS; i++) begin
            val_mem[i] = '0;
            nxt_mem[i] = alm_pkg::LINK_W'(i + 1);
            prv_mem[i] = '0;
            in_list[i] = 1'b0;
        end
        nxt_mem[0] = '0;
        free_slot = 1;
        list_len = 0;
    endfunction

    function automatic int link_after(int p, logic signed [alm_pkg::DATA_W-1:0] v);
        int n;
        int nx;
        n = free_slot;
        nx = nxt_mem[p];
        free_slot = nxt_mem[n];
        val_mem[n] = v;
        nxt_mem[n] = alm_pkg::LINK_W'(nx);
        prv_mem[n] = alm_pkg::LINK_W'(p);
        prv_mem[nx] = alm_pkg::LINK_W'(n);
        nxt_mem[p] = alm_pkg::LINK_W'(n);
        in_list[n] = 1'b1;
        list_len++;
        return n;
    endfunction

    function automatic void unlink(int n);
        int p;
        int nx;
        p = prv_mem[n];
        nx = nxt_mem[n];
        nxt_mem[p] = alm_pkg::LINK_W'(nx);
        prv_mem[nx] = alm_pkg::LINK_W'(p);
        nxt_mem[n] = alm_pkg::LINK_W'(free_slot);
        free_slot = n;
        in_list[n] = 1'b0;
        list_len--;
    endfunction

    function automatic int find_val(logic signed [alm_pkg::DATA_W-1:0] v, bit back);
        int c;
        int steps;
        c = back ? prv_mem[0] : nxt_mem[0];
        steps = 0;
        while (c != 0 && steps < alm_pkg::SLOTS) begin
            if (val_mem[c] == v) return c;
            c = back ? prv_mem[c] : nxt_mem[c];
            steps++;
        end
        return 0;
    endfunction

    function automatic alm_pkg::alm_out_t predict_list_op(alm_pkg::alm_in_t x);
        alm_pkg::alm_out_t r;
        int  loc;
        int  where;
        int  p;
        int  c;
        int  steps;
        bit  loc_ok;
        logic [alm_pkg::STAT_W-1:0] st;
        loc = x.location;
        loc_ok = loc <= alm_pkg::NODES && (loc == 0 || in_list[loc]);
        st = alm_pkg::ST_OK;
        where = 0;
        case (x.command)
            alm_pkg::CMD_INS_HEAD, alm_pkg::CMD_INS_TAIL, alm_pkg::CMD_INS_AFTER,
            alm_pkg::CMD_INS_SORTED: begin
                if (x.command == alm_pkg::CMD_INS_AFTER && !loc_ok) st = alm_pkg::ST_BAD_LOC;
                else if (free_slot > alm_pkg::NODES) st = alm_pkg::ST_OVERFLOW;
                else if (x.command == alm_pkg::CMD_INS_HEAD) where = link_after(0, x.item);
                else if (x.command == alm_pkg::CMD_INS_TAIL)
                    where = link_after(prv_mem[0], x.item);
                else if (x.command == alm_pkg::CMD_INS_AFTER) where = link_after(loc, x.item);
                else begin
                    p = 0;
                    c = nxt_mem[0];
                    steps = 0;
                    while (c != 0 && steps < alm_pkg::SLOTS && x.item >= val_mem[c]) begin
                        p = c;
                        c = nxt_mem[c];
                        steps++;
                    end
                    where = link_after(p, x.item);
                end
            end
            alm_pkg::CMD_DEL_HEAD, alm_pkg::CMD_DEL_TAIL, alm_pkg::CMD_DEL_AT,
            alm_pkg::CMD_DEL_VALUE: begin
                if (list_len == 0 || nxt_mem[0] == 0) st = alm_pkg::ST_UNDERFLOW;
                else if (x.command == alm_pkg::CMD_DEL_HEAD) where = nxt_mem[0];
                else if (x.command == alm_pkg::CMD_DEL_TAIL) where = prv_mem[0];
                else if (x.command == alm_pkg::CMD_DEL_AT) begin
                    if (loc == 0 || !loc_ok) st = alm_pkg::ST_BAD_LOC;
                    else where = loc;
                end else begin
                    where = find_val(x.item, 1'b0);
                    if (where == 0) st = alm_pkg::ST_NOT_FOUND;
                end
                if (st == alm_pkg::ST_OK) unlink(where);
            end
            alm_pkg::CMD_SRCH_FWD, alm_pkg::CMD_SRCH_BACK: begin
                where = find_val(x.item, x.command == alm_pkg::CMD_SRCH_BACK);
                if (where == 0) st = alm_pkg::ST_NOT_FOUND;
            end
            default: ;
        endcase
        r.status = st;
        r.node_location = alm_pkg::LINK_W'(where);
        r.count = alm_pkg::CNT_W'(list_len);
        return r;
    endfunction

    // random short gaps, now and then a long one
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    always @(posedge aclk) begin
        alm_pkg::alm_out_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", m_data.status, -1);
            end else begin
                w = pending_results.pop_front();
                if (m_data.status !== w.status)
                    report_mismatch("status", m_data.status, w.status);
                if (m_data.node_location !== w.node_location)
                    report_mismatch("node_location", m_data.node_location, w.node_location);
                if (m_data.count !== w.count)
                    report_mismatch("count", m_data.count, w.count);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_array_linked_list_manager_unit: done, errors");
            $finish;
        end
    end

    typedef struct {
        alm_pkg::alm_in_t  cmd;
        bit                fixed;
        alm_pkg::alm_out_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic alm_pkg::alm_in_t mk(logic [alm_pkg::CMD_W-1:0] c,
                                            logic signed [alm_pkg::DATA_W-1:0] v,
                                            logic [alm_pkg::LINK_W-1:0] l);
        alm_pkg::alm_in_t x;
        x.command = c;
        x.item = v;
        x.location = l;
        return x;
    endfunction

    function automatic alm_pkg::alm_out_t res(logic [alm_pkg::STAT_W-1:0] s, int n, int c);
        alm_pkg::alm_out_t r;
        r.status = s;
        r.node_location = alm_pkg::LINK_W'(n);
        r.count = alm_pkg::CNT_W'(c);
        return r;
    endfunction

    function automatic void add_row(alm_pkg::alm_in_t c, bit f, alm_pkg::alm_out_t w);
        dir_row_t d;
        d.cmd = c;
        d.fixed = f;
        d.want = w;
        dir_rows.push_back(d);
    endfunction

    task automatic send_item(alm_pkg::alm_in_t x, bit fixed, alm_pkg::alm_out_t want);
        alm_pkg::alm_out_t p;
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_data <= x;
        s_valid <= 1'b1;
        @(posedge aclk iff s_ready);
        p = predict_list_op(x);
        if (fixed && p != want)
            report_mismatch("table row vs predictor, status", want.status, p.status);
        pending_results.push_back(p);
    endtask

    function automatic logic signed [alm_pkg::DATA_W-1:0] rand_val();
        case ($urandom_range(0, 3))
            0: return alm_pkg::DATA_W'($urandom_range(0, 7)) - 4;
            1: return 32'sh7fffffff - alm_pkg::DATA_W'($urandom_range(0, 1));
            2: return 32'sh80000000 + alm_pkg::DATA_W'($urandom_range(0, 1));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [alm_pkg::LINK_W-1:0] rand_loc();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6 && list_len > 0) begin
            for (int t = 0; t < 8; t++) begin
                k = $urandom_range(1, alm_pkg::NODES);
                if (in_list[k]) return alm_pkg::LINK_W'(k);
            end
        end
        if ($urandom_range(0, 1)) return alm_pkg::LINK_W'($urandom_range(0, 511));
        return alm_pkg::LINK_W'($urandom_range(0, 3));
    endfunction

    function automatic logic signed [alm_pkg::DATA_W-1:0] live_val();
        int k;
        for (int t = 0; t < 8; t++) begin
            k = $urandom_range(1, alm_pkg::NODES);
            if (in_list[k]) return val_mem[k];
        end
        return rand_val();
    endfunction

    initial begin
        alm_pkg::alm_in_t x;
        int mode;
        int k;
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        err_cnt = 0;
        list_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(mk(alm_pkg::CMD_DEL_HEAD, 0, 0), 1, res(alm_pkg::ST_UNDERFLOW, 0, 0));
        add_row(mk(alm_pkg::CMD_DEL_VALUE, 5, 0), 1, res(alm_pkg::ST_UNDERFLOW, 0, 0));
        add_row(mk(alm_pkg::CMD_SRCH_FWD, 5, 0), 1, res(alm_pkg::ST_NOT_FOUND, 0, 0));
        add_row(mk(alm_pkg::CMD_INS_AFTER, 1, 9'd7), 1, res(alm_pkg::ST_BAD_LOC, 0, 0));
        add_row(mk(alm_pkg::CMD_INS_HEAD, 32'sh7fffffff, 0), 1, res(alm_pkg::ST_OK, 1, 1));
        add_row(mk(alm_pkg::CMD_INS_TAIL, 32'sh80000000, 0), 1, res(alm_pkg::ST_OK, 2, 2));
        add_row(mk(alm_pkg::CMD_INS_AFTER, 0, 0), 1, res(alm_pkg::ST_OK, 3, 3));
        add_row(mk(alm_pkg::CMD_INS_AFTER, -1, 9'd1), 1, res(alm_pkg::ST_OK, 4, 4));
        add_row(mk(alm_pkg::CMD_INS_AFTER, 3, 9'd511), 1, res(alm_pkg::ST_BAD_LOC, 0, 4));
        add_row(mk(alm_pkg::CMD_INS_SORTED, 0, 0), 0, '0);
        add_row(mk(alm_pkg::CMD_INS_SORTED, 32'sh80000000, 0), 0, '0);
        add_row(mk(alm_pkg::CMD_INS_SORTED, 32'sh7fffffff, 0), 0, '0);
        add_row(mk(alm_pkg::CMD_SRCH_FWD, 0, 0), 0, '0);
        add_row(mk(alm_pkg::CMD_SRCH_BACK, 0, 0), 0, '0);
        add_row(mk(alm_pkg::CMD_DEL_AT, 0, 0), 1, res(alm_pkg::ST_BAD_LOC, 0, 7));
        add_row(mk(alm_pkg::CMD_DEL_AT, 0, 9'd256), 1, res(alm_pkg::ST_BAD_LOC, 0, 7));
        add_row(mk(alm_pkg::CMD_DEL_AT, 0, 9'd200), 1, res(alm_pkg::ST_BAD_LOC, 0, 7));
        add_row(mk(alm_pkg::CMD_DEL_AT, 0, 9'd4), 0, '0);
        add_row(mk(alm_pkg::CMD_DEL_VALUE, 32'sh7fffffff, 0), 0, '0);
        add_row(mk(alm_pkg::CMD_DEL_VALUE, 12345, 0), 0, '0);
        add_row(mk(alm_pkg::CMD_DEL_HEAD, 0, 0), 0, '0);
        add_row(mk(alm_pkg::CMD_DEL_TAIL, 0, 0), 0, '0);
        add_row(mk(4'hf, -1, 9'h1ff), 0, '0);
        add_row(mk(4'ha, 0, 0), 0, '0);
        foreach (dir_rows[i]) send_item(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].want);

        for (int n = 0; n < 230; n++) begin
            mode = $urandom_range(0, 99);
            // one run fills the list to overflow and partly drains it
            if (n == 100) begin
                while (free_slot <= alm_pkg::NODES)
                    send_item(mk(($urandom_range(0, 1)) ? alm_pkg::CMD_INS_TAIL
                                                        : alm_pkg::CMD_INS_HEAD,
                                 rand_val(), 0), 0, '0);
                send_item(mk(alm_pkg::CMD_INS_SORTED, rand_val(), 0), 0, '0);
                send_item(mk(alm_pkg::CMD_INS_AFTER, 0, 0), 0, '0);
                send_item(mk(alm_pkg::CMD_SRCH_BACK, live_val(), 0), 0, '0);
                k = $urandom_range(60, 120);
                while (list_len > 0 && k > 0) begin
                    send_item(mk(alm_pkg::CMD_DEL_HEAD + 4'($urandom_range(0, 3)),
                                 live_val(), rand_loc()), 0, '0);
                    k--;
                end
            end
            x.item = (mode < 40) ? live_val() : rand_val();
            x.location = rand_loc();
            if (mode < 45) x.command = alm_pkg::CMD_INS_HEAD + 4'($urandom_range(0, 3));
            else if (mode < 75) x.command = alm_pkg::CMD_DEL_HEAD + 4'($urandom_range(0, 3));
            else if (mode < 97) x.command = alm_pkg::CMD_SRCH_FWD + 4'($urandom_range(0, 1));
            else x.command = 4'($urandom_range(10, 15));
            send_item(x, 0, '0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("tb_array_linked_list_manager_unit: done, clean");
        end else begin
            $display("tb_array_linked_list_manager_unit: done, errors");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/alm_pkg.sv
rtl/alm_ram.sv
rtl/alm_node_store.sv
rtl/array_linked_list_manager_unit.sv
tb/tb_array_linked_list_manager_unit.sv
